// File: hw/rtl/lzd_pkg.sv
// lzd_pkg: shared types and constants for the lz77 token decoder
// no dependencies; imported by lz77_token_decoder_unit
`default_nettype none

package lzd_pkg;

	localparam int OFFSET_W = 9;
	localparam int LENGTH_W = 6;
	localparam int BYTE_W   = 8;

	localparam int DEF_HISTORY_DEPTH = 256;
	localparam int DEF_MAX_MATCH     = 63;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_LIT
	} lzd_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/lzd_ram.sv
// lzd_ram: generic single write port, single read port ram with registered read
// read returns the old word when read and write hit the same address; no package needed
`default_nettype none

module lzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/lz77_token_decoder_unit.sv
// lz77_token_decoder_unit: lz77 token decompressor with a sliding history window
// depends on lzd_pkg and lzd_ram
//
// usage
//   token channel (tok_valid/tok_ready) carries match_offset, match_length,
//   literal_byte and final_token. byte channel (byte_valid/byte_ready) returns
//   out_byte, last_of_token and bad_offset, one transfer per decompressed byte.
//   tok_ready is high only while the sequencer is idle; a token is taken, then
//   its match bytes are read one per cycle from the history ram, appended to the
//   history and sent, followed by the literal (dropped on a final token).
//   the sequencer returns to idle before it takes the next token; the single
//   read/write port pair of the history ram sets the one byte per cycle pace
//   while byte_ready is high. the first byte is read from the history ram and
//   then registered in the output register after the token transfer.
//   a bad offset skips the copy and flags the literal, or a zero marker byte on
//   a final token. a final token with a zero length and good offset gives nothing.
//   when byte_ready is low the output register holds and the sequencer waits.
//   reset clears the write pointer and byte count; history contents stay unknown
//   and are never read before written, so no clearing pass is needed.
`default_nettype none

module lz77_token_decoder_unit
	import lzd_pkg::*;
#(
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
	parameter int MAX_MATCH     = DEF_MAX_MATCH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                tok_valid,
	output      logic                tok_ready,
	input  wire logic [OFFSET_W-1:0] match_offset,
	input  wire logic [LENGTH_W-1:0] match_length,
	input  wire logic [BYTE_W-1:0]   literal_byte,
	input  wire logic                final_token,
	output      logic                byte_valid,
	input  wire logic                byte_ready,
	output      logic [BYTE_W-1:0]   out_byte,
	output      logic                last_of_token,
	output      logic                bad_offset
);

	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int AVW = $clog2(HISTORY_DEPTH + 1);
	localparam int CW  = (OFFSET_W > AVW) ? OFFSET_W : AVW;
	localparam int SW  = CW + 1;
	localparam logic [AW-1:0]       LAST_ADDR = AW'(HISTORY_DEPTH - 1);
	localparam logic [AVW-1:0]      FULL_CNT  = AVW'(HISTORY_DEPTH);
	localparam logic [SW-1:0]       DEPTH_S   = SW'(HISTORY_DEPTH);
	localparam logic [LENGTH_W-1:0] MAX_LEN   = LENGTH_W'(MAX_MATCH);

	lzd_state_t state_q, state_d;

	logic [OFFSET_W-1:0] off_q;
	logic [LENGTH_W-1:0] len_q;
	logic [LENGTH_W-1:0] cnt_q;
	logic [BYTE_W-1:0]   lit_q;
	logic                final_q;
	logic                bad_q;
	logic [AW-1:0]       rd_q;
	logic [AW-1:0]       wp_q;
	logic [AVW-1:0]      avail_q;

	logic                byte_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                last_q;
	logic                bad_out_q;

	logic                tok_fire;
	logic                slot_free;
	logic [LENGTH_W-1:0] len_sat;
	logic                bad_in;
	logic [SW-1:0]       off_s;
	logic [SW-1:0]       wp_s;
	logic [SW-1:0]       start_s;
	logic [AW-1:0]       start_rd;
	logic [AW-1:0]       rd_next;
	logic [AW-1:0]       wp_next;
	logic [AW-1:0]       raddr;
	logic [BYTE_W-1:0]   rdata;
	logic                cnt_last;

	logic                emit;
	logic                push;
	logic [BYTE_W-1:0]   emit_byte;
	logic                emit_last;
	logic                emit_bad;

	// token decode
	always_comb begin
		len_sat = (match_length > MAX_LEN) ? MAX_LEN : match_length;
		off_s   = SW'(match_offset);
		wp_s    = SW'(wp_q);
		bad_in  = (len_sat != '0) && ((match_offset == '0) || (off_s > SW'(avail_q)));
		if (wp_s >= off_s) begin
			start_s = wp_s - off_s;
		end else begin
			start_s = wp_s + DEPTH_S - off_s;
		end
		start_rd = start_s[AW-1:0];
	end

	assign rd_next   = (rd_q == LAST_ADDR) ? '0 : rd_q + 1'b1;
	assign wp_next   = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
	assign cnt_last  = (cnt_q == len_q - 1'b1);
	assign slot_free = !byte_valid_q || byte_ready;
	assign tok_fire  = tok_valid && tok_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tok_fire) begin
					if ((len_sat != '0) && !bad_in) begin
						state_d = ST_COPY;
					end else if (!final_token || bad_in) begin
						state_d = ST_LIT;
					end
				end
			end
			ST_COPY: begin
				if (slot_free && cnt_last) begin
					state_d = final_q ? ST_IDLE : ST_LIT;
				end
			end
			ST_LIT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		tok_ready = 1'b0;
		emit      = 1'b0;
		push      = 1'b0;
		emit_byte = rdata;
		emit_last = 1'b0;
		emit_bad  = 1'b0;
		raddr     = rd_q;
		unique case (state_q)
			ST_IDLE: begin
				tok_ready = 1'b1;
				raddr     = start_rd;
			end
			ST_COPY: begin
				// offset of one reads the byte written this cycle, so repeat the last one
				emit_byte = ((off_q == OFFSET_W'(1)) && (cnt_q != '0)) ? out_byte_q : rdata;
				emit_last = final_q && cnt_last;
				if (slot_free) begin
					emit  = 1'b1;
					push  = 1'b1;
					raddr = rd_next;
				end
			end
			ST_LIT: begin
				emit_byte = final_q ? '0 : lit_q;
				emit_last = 1'b1;
				emit_bad  = bad_q;
				if (slot_free) begin
					emit = 1'b1;
					push = !final_q;
				end
			end
			default: begin
				tok_ready = 1'b0;
			end
		endcase
	end

	lzd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (push),
		.waddr(wp_q),
		.wdata(emit_byte),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wp_q         <= '0;
			avail_q      <= '0;
			byte_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				wp_q <= wp_next;
				if (avail_q != FULL_CNT) begin
					avail_q <= avail_q + 1'b1;
				end
			end
			if (emit) begin
				byte_valid_q <= 1'b1;
			end else if (byte_ready) begin
				byte_valid_q <= 1'b0;
			end
		end
	end

	// token and output payload
	always_ff @(posedge clk) begin
		if (tok_fire) begin
			off_q   <= match_offset;
			len_q   <= len_sat;
			lit_q   <= literal_byte;
			final_q <= final_token;
			bad_q   <= bad_in;
			cnt_q   <= '0;
			rd_q    <= start_rd;
		end else if (state_q == ST_COPY && emit) begin
			cnt_q <= cnt_q + 1'b1;
			rd_q  <= rd_next;
		end
		if (emit) begin
			out_byte_q <= emit_byte;
			last_q     <= emit_last;
			bad_out_q  <= emit_bad;
		end
	end

	assign byte_valid    = byte_valid_q;
	assign out_byte      = out_byte_q;
	assign last_of_token = last_q;
	assign bad_offset    = bad_out_q;

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> (cnt_q < len_q))
		else $error("copy count past match length");

	a_copy_good: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> !bad_q)
		else $error("copy running on a bad offset");

	a_avail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		avail_q <= FULL_CNT)
		else $error("byte count beyond window depth");

	a_push_emits: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> byte_valid_q)
		else $error("history write without an output byte");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tok_fire |=> !tok_ready || (state_q == ST_IDLE))
		else $error("token taken while busy");

endmodule

`default_nettype wire

// File: bench/lz77_token_decoder_checker.sv
// lz77_token_decoder_checker: watches the token and byte channels, predicts the
// decompressed byte stream from its own history window and compares it in order
// depends on lzd_pkg; instantiated beside the block by lz77_token_decoder_unit_test

module lz77_token_decoder_checker
	import lzd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tok_valid,
	input  logic                tok_ready,
	input  logic [OFFSET_W-1:0] match_offset,
	input  logic [LENGTH_W-1:0] match_length,
	input  logic [BYTE_W-1:0]   literal_byte,
	input  logic                final_token,
	input  logic                byte_valid,
	input  logic                byte_ready,
	input  logic [BYTE_W-1:0]   out_byte,
	input  logic                last_of_token,
	input  logic                bad_offset,
	output int                  fail_count,
	output int                  bytes_outstanding
);

	localparam int DEPTH   = DEF_HISTORY_DEPTH;
	localparam int AW      = $clog2(DEPTH);
	localparam int MAX_LEN = DEF_MAX_MATCH;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              bad;
	} dec_byte_t;

	logic [BYTE_W-1:0] window [DEPTH];
	int                wr_slot = 0;
	int                filled = 0;
	int                errors = 0;
	dec_byte_t         expected_bytes [$];
	dec_byte_t         want;

	assign fail_count = errors;

	function automatic void append_window(input logic [BYTE_W-1:0] b);
		window[wr_slot[AW-1:0]] = b;
		wr_slot = (wr_slot + 1) % DEPTH;
		if (filled < DEPTH)
			filled++;
	endfunction

	function automatic void queue_byte(input dec_byte_t item);
		expected_bytes.insert(expected_bytes.size(), item);
	endfunction

	task automatic decode_token(input logic [OFFSET_W-1:0] off, input logic [LENGTH_W-1:0] len,
			input logic [BYTE_W-1:0] lit, input logic fin);
		int                copy_len;
		int                rd;
		logic              skip;
		logic [BYTE_W-1:0] b;
		copy_len = (int'(len) > MAX_LEN) ? MAX_LEN : int'(len);
		skip = (copy_len > 0) && (off == '0 || int'(off) > filled);
		if (!skip) begin
			for (int j = 0; j < copy_len; j++) begin
				rd = (wr_slot + DEPTH - int'(off)) % DEPTH;
				b = window[rd[AW-1:0]];
				append_window(b);
				queue_byte('{b, fin && (j == copy_len - 1), 1'b0});
			end
		end
		if (!fin) begin
			append_window(lit);
			queue_byte('{lit, 1'b1, skip});
		end else if (skip) begin
			// bad copy on a final token leaves a zero marker byte
			queue_byte('{'0, 1'b1, 1'b1});
		end
	endtask

	task automatic note_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot = 0;
			filled = 0;
			expected_bytes.delete();
			bytes_outstanding <= 0;
		end else begin
			if (byte_valid && byte_ready) begin
				if (expected_bytes.size() == 0) begin
					note_error($sformatf("unexpected byte transfer: byte %0d last %0b bad %0b",
						out_byte, last_of_token, bad_offset));
				end else begin
					want = expected_bytes.pop_front();
					if ({out_byte, last_of_token, bad_offset} !== want)
						note_error($sformatf(
							"mismatch: exp byte %0d last %0b bad %0b, got %0d last %0b bad %0b",
							want.data, want.last, want.bad, out_byte, last_of_token, bad_offset));
				end
			end
			if (tok_valid && tok_ready)
				decode_token(match_offset, match_length, literal_byte, final_token);
			bytes_outstanding <= expected_bytes.size();
		end
	end

endmodule

// File: bench/lz77_token_decoder_unit_test.sv
// lz77_token_decoder_unit_test: clock, reset and token stimulus for the lz77 token
// decoder with random gaps and byte stalls; the checker module does the comparing
// depends on lzd_pkg, lz77_token_decoder_unit and lz77_token_decoder_checker

module lz77_token_decoder_unit_test;
	import lzd_pkg::*;

	localparam int WATCHDOG_LIMIT = 500;
	localparam int TAIL_CYCLES    = 20;
	localparam int RANDOM_TOKENS  = 112;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                tok_valid = 1'b0;
	logic                tok_ready;
	logic [OFFSET_W-1:0] match_offset = '0;
	logic [LENGTH_W-1:0] match_length = '0;
	logic [BYTE_W-1:0]   literal_byte = '0;
	logic                final_token = 1'b0;
	logic                byte_valid;
	logic                byte_ready = 1'b0;
	logic [BYTE_W-1:0]   out_byte;
	logic                last_of_token;
	logic                bad_offset;

	int fail_count;
	int bytes_outstanding;
	int fill = 0;
	int idle_cycles = 0;
	int ready_hold = 0;
	int ready_pick;

	always #6 clk = ~clk;

	lz77_token_decoder_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid    (tok_valid),
		.tok_ready    (tok_ready),
		.match_offset (match_offset),
		.match_length (match_length),
		.literal_byte (literal_byte),
		.final_token  (final_token),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.out_byte     (out_byte),
		.last_of_token(last_of_token),
		.bad_offset   (bad_offset)
	);

	lz77_token_decoder_checker u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.tok_valid        (tok_valid),
		.tok_ready        (tok_ready),
		.match_offset     (match_offset),
		.match_length     (match_length),
		.literal_byte     (literal_byte),
		.final_token      (final_token),
		.byte_valid       (byte_valid),
		.byte_ready       (byte_ready),
		.out_byte         (out_byte),
		.last_of_token    (last_of_token),
		.bad_offset       (bad_offset),
		.fail_count       (fail_count),
		.bytes_outstanding(bytes_outstanding)
	);

	// byte side stalls: long ready stretches, short stalls, a few long stalls
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			ready_pick = $urandom_range(0, 99);
			if (ready_pick < 15) begin
				byte_ready <= 1'b1;
				ready_hold <= $urandom_range(30, 80);
			end else if (ready_pick < 65) begin
				byte_ready <= 1'b1;
				ready_hold <= $urandom_range(0, 5);
			end else if (ready_pick < 95) begin
				byte_ready <= 1'b0;
				ready_hold <= $urandom_range(0, 2);
			end else begin
				byte_ready <= 1'b0;
				ready_hold <= $urandom_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin
		if ((tok_valid && tok_ready) || (byte_valid && byte_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("lz77_token_decoder_unit regression: fail");
			$finish;
		end
	end

	function automatic int pick_gap(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_token(input int gap, input logic [OFFSET_W-1:0] off,
			input logic [LENGTH_W-1:0] len, input logic [BYTE_W-1:0] lit, input logic fin);
		if (gap > 0) begin
			tok_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tok_valid    <= 1'b1;
		match_offset <= off;
		match_length <= len;
		literal_byte <= lit;
		final_token  <= fin;
		do @(posedge clk); while (!tok_ready);
		// rough fill level, only to steer offsets toward good copies
		if (len != '0 && off != '0 && int'(off) <= fill)
			fill += int'(len);
		if (!fin)
			fill++;
		if (fill > DEF_HISTORY_DEPTH)
			fill = DEF_HISTORY_DEPTH;
	endtask

	initial begin
		int                  pick;
		int                  near_max;
		bit                  burst;
		logic [OFFSET_W-1:0] off;
		logic [LENGTH_W-1:0] len;
		logic                fin;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// copy before any history, then plain literals with ignored offsets
		send_token(pick_gap(1'b0), 9'd1,   6'd5,  8'h5A, 1'b0);
		send_token(pick_gap(1'b0), 9'd0,   6'd0,  8'h00, 1'b0);
		send_token(pick_gap(1'b0), 9'd511, 6'd0,  8'hFF, 1'b0);
		// overlapping runs
		send_token(pick_gap(1'b0), 9'd1,   6'd10, 8'hA5, 1'b0);
		send_token(pick_gap(1'b0), 9'd3,   6'd63, 8'h3C, 1'b0);
		// offset equal to fill level, then one beyond it, then zero
		send_token(pick_gap(1'b0), 9'd78,  6'd63, 8'h01, 1'b0);
		send_token(pick_gap(1'b0), 9'd143, 6'd2,  8'h02, 1'b0);
		send_token(pick_gap(1'b0), 9'd0,   6'd7,  8'h80, 1'b0);
		// fill the window past its depth
		send_token(pick_gap(1'b0), 9'd100, 6'd63, 8'h7E, 1'b0);
		send_token(pick_gap(1'b0), 9'd200, 6'd63, 8'h11, 1'b0);
		send_token(pick_gap(1'b0), 9'd256, 6'd63, 8'h22, 1'b0);
		send_token(pick_gap(1'b0), 9'd257, 6'd1,  8'h33, 1'b0);
		send_token(pick_gap(1'b0), 9'd511, 6'd63, 8'h44, 1'b0);
		// final tokens: marker, nothing, copy only, marker
		send_token(pick_gap(1'b0), 9'd0,   6'd3,  8'h66, 1'b1);
		send_token(pick_gap(1'b0), 9'd5,   6'd0,  8'h77, 1'b1);
		send_token(pick_gap(1'b0), 9'd1,   6'd4,  8'h88, 1'b1);
		send_token(pick_gap(1'b0), 9'd300, 6'd63, 8'h99, 1'b1);
		send_token(pick_gap(1'b0), 9'd17,  6'd1,  8'h55, 1'b0);

		for (int i = 0; i < RANDOM_TOKENS; i++) begin
			burst = (i % 40) >= 30;
			pick = $urandom_range(0, 99);
			fin = ($urandom_range(0, 99) < 8);
			if (pick < 10) begin
				off = OFFSET_W'($urandom);
				len = '0;
			end else if (pick < 22 || fill == 0) begin
				off = ($urandom_range(0, 1) != 0) ? '0
					: OFFSET_W'($urandom_range(fill + 1, 511));
				len = LENGTH_W'($urandom_range(1, 63));
			end else begin
				near_max = (fill < 8) ? fill : 8;
				off = ($urandom_range(0, 1) != 0) ? OFFSET_W'($urandom_range(1, near_max))
					: OFFSET_W'($urandom_range(1, fill));
				len = ($urandom_range(0, 99) < 85) ? LENGTH_W'($urandom_range(1, 8))
					: LENGTH_W'($urandom_range(9, 63));
			end
			send_token(pick_gap(burst), off, len, BYTE_W'($urandom), fin);
		end
		tok_valid <= 1'b0;

		@(posedge clk);
		while (bytes_outstanding != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("lz77_token_decoder_unit regression: pass");
		else
			$display("lz77_token_decoder_unit regression: fail");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/lzd_pkg.sv
hw/rtl/lzd_ram.sv
hw/rtl/lz77_token_decoder_unit.sv
bench/lz77_token_decoder_checker.sv
bench/lz77_token_decoder_unit_test.sv
